// File: rtl/bawf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bawf_pkg;

  // Operation codes carried in the request's tuser field
  typedef enum logic [4:0] {
    OP_ADD  = 5'd0,
    OP_ADC  = 5'd1,
    OP_SUB  = 5'd2,
    OP_SBB  = 5'd3,
    OP_ANA  = 5'd4,
    OP_XRA  = 5'd5,
    OP_ORA  = 5'd6,
    OP_CMP  = 5'd7,
    OP_INR  = 5'd8,
    OP_DCR  = 5'd9,
    OP_RLC  = 5'd10,
    OP_RRC  = 5'd11,
    OP_RAL  = 5'd12,
    OP_RAR  = 5'd13,
    OP_DAA  = 5'd14,
    OP_CMA  = 5'd15,
    OP_CMC  = 5'd16,
    OP_STC  = 5'd17,
    OP_DAD  = 5'd18,
    OP_COND = 5'd19
  } op_t;

  // Branch condition codes
  typedef enum logic [2:0] {
    COND_NZ = 3'd0,
    COND_Z  = 3'd1,
    COND_NC = 3'd2,
    COND_C  = 3'd3,
    COND_PO = 3'd4,
    COND_PE = 3'd5,
    COND_P  = 3'd6,
    COND_M  = 3'd7
  } cond_t;

  // Flag byte bit positions
  localparam int unsigned FLAG_S  = 7;
  localparam int unsigned FLAG_Z  = 6;
  localparam int unsigned FLAG_AC = 4;
  localparam int unsigned FLAG_P  = 2;
  localparam int unsigned FLAG_CY = 0;

  // Decimal adjust corrections
  localparam logic [7:0] DAA_LO_CORR = 8'h06;
  localparam logic [7:0] DAA_HI_CORR = 8'h60;
  localparam logic [3:0] BCD_NINE    = 4'h9;

  typedef struct packed {
    logic [2:0]  cond_code;
    logic [4:0]  req_type;
    logic [15:0] pair_in;
    logic [15:0] hl_in;
    logic [7:0]  operand;
    logic [7:0]  flags_in;
    logic [7:0]  acc_in;
  } req_t;

  typedef struct packed {
    logic        cond_true;
    logic [15:0] hl_out;
    logic [7:0]  result_byte;
    logic [7:0]  flags_out;
    logic [7:0]  acc_out;
  } res_t;

endpackage

`default_nettype wire

// File: rtl/bawf_core.sv
`timescale 1ns / 1ps
`default_nettype none

module bawf_core (
  input  wire bawf_pkg::req_t req,
  output bawf_pkg::res_t      res
);

  // Build a flag byte from an 8-bit result; bits 5, 3, 1 come from the old flags
  function automatic logic [7:0] mk_flags(input logic [7:0] r, input logic ac,
                                          input logic c, input logic [7:0] fi);
    mk_flags = {r[7], (r == 8'h00), fi[5], ac, fi[3], ~(^r), fi[1], c};
  endfunction

  logic [7:0] a;
  logic [7:0] b;
  logic [7:0] fi;
  logic       cy;
  logic [7:0] add_b;
  logic       add_cin;
  logic [8:0] add_sum;
  logic [4:0] add_nib;
  logic       daa_lo;
  logic       daa_hi;
  logic [7:0] inr_r;
  logic [7:0] dcr_r;
  logic [16:0] dad_sum;
  logic       cond_ok;

  assign a  = req.acc_in;
  assign b  = req.operand;
  assign fi = req.flags_in;
  assign cy = fi[bawf_pkg::FLAG_CY];

  // Decimal adjust decisions
  assign daa_lo = fi[bawf_pkg::FLAG_AC] || (a[3:0] > bawf_pkg::BCD_NINE);
  assign daa_hi = cy || (a[7:4] > bawf_pkg::BCD_NINE) ||
                  ((a[7:4] >= bawf_pkg::BCD_NINE) && (a[3:0] > bawf_pkg::BCD_NINE));

  // One shared byte adder for add, subtract, compare and decimal adjust
  always_comb begin
    add_b   = b;
    add_cin = 1'b0;
    unique case (req.req_type)
      bawf_pkg::OP_ADC: begin
        add_cin = cy;
      end
      bawf_pkg::OP_SUB, bawf_pkg::OP_CMP: begin
        add_b   = ~b;
        add_cin = 1'b1;
      end
      bawf_pkg::OP_SBB: begin
        add_b   = ~b;
        add_cin = ~cy;
      end
      bawf_pkg::OP_DAA: begin
        add_b = (daa_lo ? bawf_pkg::DAA_LO_CORR : 8'h00) |
                (daa_hi ? bawf_pkg::DAA_HI_CORR : 8'h00);
      end
      default: begin
        add_b   = b;
        add_cin = 1'b0;
      end
    endcase
  end

  assign add_sum = {1'b0, a} + {1'b0, add_b} + {8'h00, add_cin};
  assign add_nib = {1'b0, a[3:0]} + {1'b0, add_b[3:0]} + {4'h0, add_cin};
  assign inr_r   = b + 8'h01;
  assign dcr_r   = b - 8'h01;
  assign dad_sum = {1'b0, req.hl_in} + {1'b0, req.pair_in};

  always_comb begin
    res.acc_out     = a;
    res.flags_out   = fi;
    res.result_byte = 8'h00;
    res.hl_out      = req.hl_in;
    res.cond_true   = cond_ok;
    unique case (req.req_type)
      bawf_pkg::OP_ADD, bawf_pkg::OP_ADC: begin
        res.acc_out   = add_sum[7:0];
        res.flags_out = mk_flags(add_sum[7:0], add_nib[4], add_sum[8], fi);
      end
      bawf_pkg::OP_SUB, bawf_pkg::OP_SBB: begin
        // carry out of the complement add is the inverse of the borrow
        res.acc_out   = add_sum[7:0];
        res.flags_out = mk_flags(add_sum[7:0], add_nib[4], ~add_sum[8], fi);
      end
      bawf_pkg::OP_CMP: begin
        res.flags_out = mk_flags(add_sum[7:0], add_nib[4], ~add_sum[8], fi);
      end
      bawf_pkg::OP_ANA: begin
        res.acc_out   = a & b;
        res.flags_out = mk_flags(a & b, a[3] | b[3], 1'b0, fi);
      end
      bawf_pkg::OP_XRA: begin
        res.acc_out   = a ^ b;
        res.flags_out = mk_flags(a ^ b, 1'b0, 1'b0, fi);
      end
      bawf_pkg::OP_ORA: begin
        res.acc_out   = a | b;
        res.flags_out = mk_flags(a | b, 1'b0, 1'b0, fi);
      end
      bawf_pkg::OP_INR: begin
        res.result_byte = inr_r;
        res.flags_out   = mk_flags(inr_r, inr_r[3:0] == 4'h0, cy, fi);
      end
      bawf_pkg::OP_DCR: begin
        res.result_byte = dcr_r;
        res.flags_out   = mk_flags(dcr_r, dcr_r[3:0] != 4'hF, cy, fi);
      end
      bawf_pkg::OP_RLC: begin
        res.acc_out   = {a[6:0], a[7]};
        res.flags_out = {fi[7:1], a[7]};
      end
      bawf_pkg::OP_RRC: begin
        res.acc_out   = {a[0], a[7:1]};
        res.flags_out = {fi[7:1], a[0]};
      end
      bawf_pkg::OP_RAL: begin
        res.acc_out   = {a[6:0], cy};
        res.flags_out = {fi[7:1], a[7]};
      end
      bawf_pkg::OP_RAR: begin
        res.acc_out   = {cy, a[7:1]};
        res.flags_out = {fi[7:1], a[0]};
      end
      bawf_pkg::OP_DAA: begin
        // carry sets on a high correction, otherwise holds
        res.acc_out   = add_sum[7:0];
        res.flags_out = mk_flags(add_sum[7:0], add_nib[4], daa_hi | cy, fi);
      end
      bawf_pkg::OP_CMA: begin
        res.acc_out = ~a;
      end
      bawf_pkg::OP_CMC: begin
        res.flags_out = {fi[7:1], ~cy};
      end
      bawf_pkg::OP_STC: begin
        res.flags_out = {fi[7:1], 1'b1};
      end
      bawf_pkg::OP_DAD: begin
        res.hl_out    = dad_sum[15:0];
        res.flags_out = {fi[7:1], dad_sum[16]};
      end
      default: begin
        res.acc_out = a;
      end
    endcase
  end

  // Branch condition, evaluated on the incoming flags for every request
  always_comb begin
    unique case (bawf_pkg::cond_t'(req.cond_code))
      bawf_pkg::COND_NZ: cond_ok = ~fi[bawf_pkg::FLAG_Z];
      bawf_pkg::COND_Z:  cond_ok =  fi[bawf_pkg::FLAG_Z];
      bawf_pkg::COND_NC: cond_ok = ~fi[bawf_pkg::FLAG_CY];
      bawf_pkg::COND_C:  cond_ok =  fi[bawf_pkg::FLAG_CY];
      bawf_pkg::COND_PO: cond_ok = ~fi[bawf_pkg::FLAG_P];
      bawf_pkg::COND_PE: cond_ok =  fi[bawf_pkg::FLAG_P];
      bawf_pkg::COND_P:  cond_ok = ~fi[bawf_pkg::FLAG_S];
      bawf_pkg::COND_M:  cond_ok =  fi[bawf_pkg::FLAG_S];
      default:           cond_ok = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/byte_alu_with_flags_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// 8080-style accumulator ALU with flag logic.
// Request channel (s_axis): one transaction carries one operation. tuser selects
// the operation and the branch condition; tdata carries accumulator, flags,
// operand byte, HL and the register pair.
// Result channel (m_axis): one transaction per request, in request order, with
// the new accumulator, new flags, INR/DCR result byte, new HL and the
// condition-test bit.
// Path: an accepted request is captured in the input register, then its core
// result is captured in the result register that drives m_axis.
// Throughput: one transaction per cycle while m_axis_tready is high; between the
// two register stages: byte/nibble adders, INR/DCR, 16-bit adder, flag/cond select.
// Reset: rst (synchronous, active high) empties both stages; s_axis_tready is
// high from the first cycle after reset.
// Stall: while m_axis_tready is low a waiting result holds; the input stage
// still fills if it is empty, then s_axis_tready drops until the result drains.
// No transaction is dropped or repeated.

module byte_alu_with_flags_unit (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] acc_in, [15:8] flags_in, [23:16] operand, [39:24] hl_in, [55:40] pair_in
  input  wire  [55:0] s_axis_tdata,
  // [4:0] req_type, [7:5] cond_code
  input  wire  [7:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // [7:0] acc_out, [15:8] flags_out, [23:16] result_byte, [39:24] hl_out,
  // [40] cond_true, [47:41] zero
  output logic [47:0] m_axis_tdata
);

  bawf_pkg::req_t in_req;
  logic           in_valid;
  bawf_pkg::res_t core_res;
  bawf_pkg::res_t out_res;
  logic           out_adv;

  // The result register takes a new value when it is empty or being drained
  assign out_adv       = ~m_axis_tvalid | m_axis_tready;
  assign s_axis_tready = ~in_valid | out_adv;

  // Input register: capture the request fields as one packed struct
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_req.acc_in    <= s_axis_tdata[7:0];
      in_req.flags_in  <= s_axis_tdata[15:8];
      in_req.operand   <= s_axis_tdata[23:16];
      in_req.hl_in     <= s_axis_tdata[39:24];
      in_req.pair_in   <= s_axis_tdata[55:40];
      in_req.req_type  <= s_axis_tuser[4:0];
      in_req.cond_code <= s_axis_tuser[7:5];
    end
  end

  bawf_core u_core (
    .req (in_req),
    .res (core_res)
  );

  // Result register: advance when the downstream side can take it
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_adv) begin
      m_axis_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && in_valid) begin
      out_res <= core_res;
    end
  end

  assign m_axis_tdata = {7'h00, out_res.cond_true, out_res.hl_out, out_res.result_byte,
                         out_res.flags_out, out_res.acc_out};

endmodule

`default_nettype wire
